FILE: hdl/lspd_pkg.sv
`timescale 1ns / 1ps
// Package: shared constants, controller states and command/status types of the line sensor block.
package lspd_pkg;

  localparam int NUM_SENSORS  = 8;
  localparam int SPAN         = NUM_SENSORS - 1;
  localparam int Q_BITS       = 14;
  localparam int DETECT_RUN   = 3;

  localparam int CNT_W  = 4;
  localparam int SUM_W  = 5;
  localparam int DEN_W  = 6;
  localparam int REM_W  = DEN_W + 1;
  localparam int QUO_W  = Q_BITS + 1;
  localparam int POS_W  = 16;
  localparam int DIV_STEPS = QUO_W;
  localparam int STEP_W = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic last_step;
  } dp_sts_t;

endpackage

FILE: hdl/lspd_datapath.sv
`timescale 1ns / 1ps
// Datapath: mask and count, detect run tracking, shift-subtract divider and output registers.
module lspd_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lspd_pkg::dp_cmd_t         cmd_i,
  output lspd_pkg::dp_sts_t         sts_o,
  input  logic [7:0]                sensor_levels_i,
  output logic signed [15:0]        position_q_o,
  output logic [7:0]                active_mask_o,
  output logic [3:0]                active_count_o,
  output logic                      detected_o
);

  logic [7:0]                    mask_c;
  logic [lspd_pkg::CNT_W-1:0]    cnt_c;
  logic [lspd_pkg::SUM_W-1:0]    sum_c;
  logic [lspd_pkg::DEN_W-1:0]    den_c;
  logic [7:0]                    diff_c;
  logic [7:0]                    abs_c;
  logic [1:0]                    run_c;
  logic                          present_c;

  logic [7:0]                    mask_q;
  logic [lspd_pkg::CNT_W-1:0]    cnt_q;
  logic [lspd_pkg::DEN_W-1:0]    den_q;
  logic [lspd_pkg::REM_W-1:0]    rem_q, rem_d;
  logic [lspd_pkg::QUO_W-1:0]    quo_q, quo_d;
  logic                          neg_q;
  logic                          zero_q;
  logic                          det_q;
  logic [lspd_pkg::STEP_W-1:0]   step_q;
  logic [1:0]                    seen_run_q;
  logic                          line_present_q;

  logic                          ge_c;
  logic [lspd_pkg::REM_W-1:0]    rdiff_c;
  logic [lspd_pkg::POS_W-1:0]    pos_c;

  always_comb begin
    mask_c = ~sensor_levels_i;
    cnt_c  = '0;
    sum_c  = '0;
    for (int i = 0; i < lspd_pkg::NUM_SENSORS; i++) begin
      if (mask_c[i]) begin
        cnt_c = cnt_c + 1'b1;
        sum_c = sum_c + lspd_pkg::SUM_W'(i);
      end
    end
    den_c  = lspd_pkg::DEN_W'(cnt_c * lspd_pkg::SPAN);
    diff_c = {2'b00, sum_c, 1'b0} - {2'b00, den_c};
    abs_c  = diff_c[7] ? (8'd0 - diff_c) : diff_c;

    if (cnt_c == '0) begin
      run_c     = 2'd0;
      present_c = 1'b0;
    end else if (!line_present_q) begin
      run_c     = (seen_run_q < 2'(lspd_pkg::DETECT_RUN)) ? seen_run_q + 2'd1 : seen_run_q;
      present_c = (run_c == 2'(lspd_pkg::DETECT_RUN));
    end else begin
      run_c     = seen_run_q;
      present_c = 1'b1;
    end
  end

  // One quotient bit per step; the held remainder stays below twice the divisor.
  always_comb begin
    ge_c    = rem_q >= {1'b0, den_q};
    rdiff_c = ge_c ? (rem_q - {1'b0, den_q}) : rem_q;
    rem_d   = {rdiff_c[lspd_pkg::REM_W-2:0], 1'b0};
    quo_d   = {quo_q[lspd_pkg::QUO_W-2:0], ge_c};
    if (zero_q) begin
      pos_c = '0;
    end else if (neg_q) begin
      pos_c = lspd_pkg::POS_W'(0) - {1'b0, quo_q};
    end else begin
      pos_c = {1'b0, quo_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_run_q     <= 2'd0;
      line_present_q <= 1'b0;
      step_q         <= '0;
    end else begin
      if (cmd_i.load) begin
        seen_run_q     <= run_c;
        line_present_q <= present_c;
        step_q         <= '0;
      end else if (cmd_i.step) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mask_q <= mask_c;
      cnt_q  <= cnt_c;
      den_q  <= den_c;
      rem_q  <= abs_c[lspd_pkg::REM_W-1:0];
      quo_q  <= '0;
      neg_q  <= diff_c[7];
      zero_q <= (cnt_c == '0);
      det_q  <= present_c;
    end else if (cmd_i.step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (cmd_i.publish) begin
      position_q_o   <= pos_c;
      active_mask_o  <= mask_q;
      active_count_o <= cnt_q;
      detected_o     <= det_q;
    end
  end

  assign sts_o.last_step = (step_q == lspd_pkg::STEP_W'(lspd_pkg::DIV_STEPS - 1));

  a_load_clears_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> step_q == '0)
    else $error("step counter not cleared by load");

  a_rem_below_twice_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && !zero_q) |-> rem_q < {den_q, 1'b0})
    else $error("divider remainder out of range");

  a_publish_copies_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |=> active_mask_o == $past(mask_q))
    else $error("published mask differs from held mask");

endmodule

FILE: hdl/lspd_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences load, divide steps and publish, and owns the handshakes.
module lspd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lspd_pkg::dp_cmd_t  cmd_o,
  input  lspd_pkg::dp_sts_t  sts_i
);

  lspd_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lspd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      lspd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lspd_pkg::ST_DIV;
        end
      end
      lspd_pkg::ST_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.last_step) begin
          state_d = lspd_pkg::ST_HOLD;
        end
      end
      lspd_pkg::ST_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = lspd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lspd_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_load_enters_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == lspd_pkg::ST_DIV)
    else $error("load did not start the divide");

  a_publish_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |=> out_valid_q)
    else $error("published result not marked valid");

  a_div_runs_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lspd_pkg::ST_DIV && !sts_i.last_step) |=> state_q == lspd_pkg::ST_DIV)
    else $error("divide left before its last step");

endmodule

FILE: hdl/line_sensor_position_and_detect_top.sv
`timescale 1ns / 1ps
// Top level: line sensor position and detect block.
//
// Takes one request per sample of eight active-low light sensors and returns one result:
// the active mask (inverted levels), the count of active sensors, a signed Q1.14 line
// position (mean of (i-3.5)/3.5 over active sensors, truncated toward zero, 0 when none
// is active) and a detect flag that sets after three non-empty samples in a row and
// clears on the first empty one. The sample is loaded at the edge that accepts the request,
// the one-bit-per-cycle shift-subtract divider then runs, and the result is moved into the
// output register once that register is free (out_ready_i can hold it back). The
// controller returns to idle as the result is published, so a new request is taken only
// after the previous sample has been published. A finished result waits in the output
// register, so the next sample can be accepted while the previous result is still
// unread; a new result is only published once the old one has been taken.
module line_sensor_position_and_detect_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         sensor_levels_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] position_q_o,
  output logic [7:0]         active_mask_o,
  output logic [3:0]         active_count_o,
  output logic               detected_o
);

  // Commands from the controller, status back from the datapath.
  lspd_pkg::dp_cmd_t cmd;
  lspd_pkg::dp_sts_t sts;

  // Sequence the request through load, divide and publish.
  lspd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Hold the sample's mask, count and detect state; run the divider.
  lspd_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .sensor_levels_i (sensor_levels_i),
    .position_q_o    (position_q_o),
    .active_mask_o   (active_mask_o),
    .active_count_o  (active_count_o),
    .detected_o      (detected_o)
  );

endmodule
